// File: rtl/dlf_pkg.sv
package dlf_pkg;

	// Payload widths
	localparam int POWER_W = 32;
	localparam int LEVEL_W = 7;
	localparam int ACC_W   = 14;
	localparam int K_W     = 4;

	// Normalization limits
	localparam logic [31:0] BIG_LIMIT  = 32'd1000000;
	localparam logic [31:0] MANT_LIMIT = 32'd10000;
	localparam logic [31:0] MANT_LOW   = 32'd1000;

	// Accumulator steps: one decade, and the first root step
	localparam logic [ACC_W-1:0] DEC_STEP = 14'd1000;
	localparam logic [8:0]       HALF_DEC = 9'd500;

	// Rounded divide by ten: floor(v / 10) = (v * DIV10_RECIP) >> DIV10_SHIFT
	localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
	localparam int          DIV10_SHIFT = 35;

	// Root step divide: floor(n / c) = (n * ceil(2^36 / c)) >> 36 for n below 2^24
	localparam int            ROOT_SHIFT = 36;
	localparam int            QUOT_W     = 14;
	localparam logic [K_W-1:0] ROOT_STEPS = 4'd10;
	localparam logic [63:0]   RECIP_ONE  = 64'd1 << ROOT_SHIFT;

	localparam logic [26:0] RECIP_3162 = 27'((RECIP_ONE + 64'd3162 - 64'd1) / 64'd3162);
	localparam logic [26:0] RECIP_1778 = 27'((RECIP_ONE + 64'd1778 - 64'd1) / 64'd1778);
	localparam logic [26:0] RECIP_1334 = 27'((RECIP_ONE + 64'd1334 - 64'd1) / 64'd1334);
	localparam logic [26:0] RECIP_1155 = 27'((RECIP_ONE + 64'd1155 - 64'd1) / 64'd1155);
	localparam logic [26:0] RECIP_1075 = 27'((RECIP_ONE + 64'd1075 - 64'd1) / 64'd1075);
	localparam logic [26:0] RECIP_1037 = 27'((RECIP_ONE + 64'd1037 - 64'd1) / 64'd1037);
	localparam logic [26:0] RECIP_1018 = 27'((RECIP_ONE + 64'd1018 - 64'd1) / 64'd1018);
	localparam logic [26:0] RECIP_1009 = 27'((RECIP_ONE + 64'd1009 - 64'd1) / 64'd1009);
	localparam logic [26:0] RECIP_1005 = 27'((RECIP_ONE + 64'd1005 - 64'd1) / 64'd1005);
	localparam logic [26:0] RECIP_1002 = 27'((RECIP_ONE + 64'd1002 - 64'd1) / 64'd1002);

	// Output: (acc + 50) / 100 = ((acc + 50) * 5243) >> 19 for values below 43690
	localparam logic [ACC_W-1:0] OUT_BIAS  = 14'd50;
	localparam logic [12:0]      OUT_RECIP = 13'd5243;
	localparam int               OUT_SHIFT = 19;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RED,
		S_SCALE,
		S_NORM,
		S_ROOT,
		S_MUL,
		S_WB,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		PH_RED,
		PH_NORM,
		PH_ROOT
	} phase_t;

	typedef struct packed {
		logic           load;
		logic           scale;
		logic           prep_div10;
		logic           prep_root;
		logic           mul;
		logic           wb_div10;
		logic           wb_root;
		logic           finish;
		logic [K_W-1:0] k;
	} cmd_t;

	typedef struct packed {
		logic v_ge_big;
		logic v_ge_mant;
		logic root_fits;
	} stat_t;

	// Approximations of 1000 * 10^(1/2^(k+1))
	function automatic logic [11:0] root_const(input logic [K_W-1:0] k);
		case (k)
			4'd0:    return 12'd3162;
			4'd1:    return 12'd1778;
			4'd2:    return 12'd1334;
			4'd3:    return 12'd1155;
			4'd4:    return 12'd1075;
			4'd5:    return 12'd1037;
			4'd6:    return 12'd1018;
			4'd7:    return 12'd1009;
			4'd8:    return 12'd1005;
			4'd9:    return 12'd1002;
			default: return 12'd0;
		endcase
	endfunction

	function automatic logic [26:0] root_recip(input logic [K_W-1:0] k);
		case (k)
			4'd0:    return RECIP_3162;
			4'd1:    return RECIP_1778;
			4'd2:    return RECIP_1334;
			4'd3:    return RECIP_1155;
			4'd4:    return RECIP_1075;
			4'd5:    return RECIP_1037;
			4'd6:    return RECIP_1018;
			4'd7:    return RECIP_1009;
			4'd8:    return RECIP_1005;
			4'd9:    return RECIP_1002;
			default: return 27'd0;
		endcase
	endfunction

endpackage

// File: rtl/dlf_power_if.sv
interface dlf_power_if;
	logic                        valid;
	logic                        ready;
	logic [dlf_pkg::POWER_W-1:0] power_value;

	modport source (output valid, output power_value, input ready);
	modport sink (input valid, input power_value, output ready);
endinterface

// File: rtl/dlf_level_if.sv
interface dlf_level_if;
	logic                        valid;
	logic                        ready;
	logic [dlf_pkg::LEVEL_W-1:0] level_db;

	modport source (output valid, output level_db, input ready);
	modport sink (input valid, input level_db, output ready);
endinterface

// File: rtl/dlf_ctrl.sv
module dlf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  dlf_pkg::stat_t stat,
	output dlf_pkg::cmd_t  cmd
);

	dlf_pkg::state_t                state_q, state_d;
	dlf_pkg::phase_t                phase_q, phase_d;
	logic [dlf_pkg::K_W-1:0]        k_q, k_d;
	logic                           out_valid_q;

	// State, phase and root index registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlf_pkg::S_IDLE;
			phase_q <= dlf_pkg::PH_RED;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			k_q     <= k_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		k_d      = k_q;
		cmd      = '0;
		cmd.k    = k_q;
		in_ready = 1'b0;
		unique case (state_q)
			dlf_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = dlf_pkg::S_RED;
				end
			end
			dlf_pkg::S_RED: begin
				if (stat.v_ge_big) begin
					cmd.prep_div10 = 1'b1;
					phase_d        = dlf_pkg::PH_RED;
					state_d        = dlf_pkg::S_MUL;
				end else begin
					state_d = dlf_pkg::S_SCALE;
				end
			end
			dlf_pkg::S_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = dlf_pkg::S_NORM;
			end
			dlf_pkg::S_NORM: begin
				if (stat.v_ge_mant) begin
					cmd.prep_div10 = 1'b1;
					phase_d        = dlf_pkg::PH_NORM;
					state_d        = dlf_pkg::S_MUL;
				end else begin
					k_d     = '0;
					state_d = dlf_pkg::S_ROOT;
				end
			end
			dlf_pkg::S_ROOT: begin
				if (k_q == dlf_pkg::ROOT_STEPS) begin
					state_d = dlf_pkg::S_DONE;
				end else if (stat.root_fits) begin
					cmd.prep_root = 1'b1;
					phase_d       = dlf_pkg::PH_ROOT;
					state_d       = dlf_pkg::S_MUL;
				end else begin
					k_d = dlf_pkg::K_W'(k_q + 4'd1);
				end
			end
			dlf_pkg::S_MUL: begin
				cmd.mul = 1'b1;
				state_d = dlf_pkg::S_WB;
			end
			dlf_pkg::S_WB: begin
				unique case (phase_q)
					dlf_pkg::PH_RED: begin
						cmd.wb_div10 = 1'b1;
						state_d      = dlf_pkg::S_RED;
					end
					dlf_pkg::PH_NORM: begin
						cmd.wb_div10 = 1'b1;
						state_d      = dlf_pkg::S_NORM;
					end
					dlf_pkg::PH_ROOT: begin
						cmd.wb_root = 1'b1;
						k_d         = dlf_pkg::K_W'(k_q + 4'd1);
						state_d     = dlf_pkg::S_ROOT;
					end
					default: begin
						state_d = dlf_pkg::S_IDLE;
					end
				endcase
			end
			dlf_pkg::S_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = dlf_pkg::S_IDLE;
				end
			end
		endcase
	end

	// Output valid: set on finish, drop when the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= dlf_pkg::ROOT_STEPS)
		else $error("root index beyond table");

	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished word not presented");

	a_wb_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dlf_pkg::S_WB) |-> $past(state_q == dlf_pkg::S_MUL))
		else $error("write-back without a product");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.finish)
		else $error("pending word overwritten");

endmodule

// File: rtl/dlf_dpath.sv
module dlf_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dlf_pkg::cmd_t               cmd,
	output dlf_pkg::stat_t              stat,
	input  logic [dlf_pkg::POWER_W-1:0] power_value,
	output logic [dlf_pkg::LEVEL_W-1:0] level_db
);

	logic [31:0]                 v_q;
	logic [dlf_pkg::ACC_W-1:0]   acc_q;
	logic [31:0]                 opnd_q;
	logic [31:0]                 recip_q;
	logic [63:0]                 prod_q;
	logic [dlf_pkg::LEVEL_W-1:0] level_q;

	logic [31:0]               v_x1000;
	logic [11:0]               root_c;
	logic [28:0]               quot10;
	logic [31:0]               ten_quot;
	logic [31:0]               rem10;
	logic [dlf_pkg::ACC_W-1:0] out_sum;
	logic [26:0]               out_prod;

	// Shift-add multiply by 1000, and the current root constant
	assign v_x1000 = (v_q << 10) - (v_q << 4) - (v_q << 3);
	assign root_c  = dlf_pkg::root_const(cmd.k);

	// Quotient and remainder of the divide by ten
	assign quot10   = prod_q[63:dlf_pkg::DIV10_SHIFT];
	assign ten_quot = 32'({quot10, 3'b000}) + 32'({quot10, 1'b0});
	assign rem10    = v_q - ten_quot;

	// Status to the controller
	assign stat.v_ge_big  = (v_q >= dlf_pkg::BIG_LIMIT);
	assign stat.v_ge_mant = (v_q >= dlf_pkg::MANT_LIMIT);
	assign stat.root_fits = (32'(root_c) <= v_q);

	// Working value and accumulator
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q   <= power_value;
			acc_q <= '0;
		end else if (cmd.scale) begin
			v_q <= v_x1000;
		end else if (cmd.wb_div10) begin
			v_q   <= 32'(quot10) + 32'(rem10[3:0] >= 4'd5);
			acc_q <= acc_q + dlf_pkg::DEC_STEP;
		end else if (cmd.wb_root) begin
			v_q   <= 32'(prod_q[dlf_pkg::ROOT_SHIFT +: dlf_pkg::QUOT_W]);
			acc_q <= acc_q + dlf_pkg::ACC_W'(dlf_pkg::HALF_DEC >> cmd.k);
		end
	end

	// Multiplier operands: dividend (rounded for a root step) and reciprocal
	always_ff @(posedge clk) begin
		if (cmd.prep_div10) begin
			opnd_q  <= v_q;
			recip_q <= dlf_pkg::DIV10_RECIP;
		end else if (cmd.prep_root) begin
			opnd_q  <= v_x1000 + 32'(root_c[11:1]);
			recip_q <= 32'(dlf_pkg::root_recip(cmd.k));
		end
	end

	// Shared multiplier
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= opnd_q * recip_q;
		end
	end

	// Output scaling: (acc + 50) / 100
	assign out_sum  = acc_q + dlf_pkg::OUT_BIAS;
	assign out_prod = 27'(out_sum) * 27'(dlf_pkg::OUT_RECIP);

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			level_q <= out_prod[dlf_pkg::OUT_SHIFT +: dlf_pkg::LEVEL_W];
		end
	end

	assign level_db = level_q;

	a_div_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wb_div10 |=> (v_q <= $past(v_q)))
		else $error("divide by ten grew the value");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wb_root |=> (v_q >= dlf_pkg::MANT_LOW && v_q < dlf_pkg::MANT_LIMIT))
		else $error("mantissa left its range after a root step");

endmodule

// File: rtl/decibel_log10_fixed_core.sv
// Decibel level of a linear power value: level_db = round(10 * log10(power_value)).
// Channel sample carries one 32-bit unsigned power_value per word; channel result
// returns one 7-bit level_db per accepted word, in order. A zero input gives 0.
// One word is worked on at a time: sample.ready is high only while the core idles.
// The finished level sits in an output register, so the next sample is taken
// while a level still waits on a stalled result channel; the core then holds its
// following level until the register frees.
// The number of divide-by-ten decades is at most 9 and the number of root table
// hits at most 10. Each division costs three controller steps (operand load,
// product, write-back) on the one shared 32x32 multiplier.
// Reset (arst_n low) returns the controller to idle and drops result.valid; no
// clearing pass is needed.
module decibel_log10_fixed_core (
	input logic         clk,
	input logic         arst_n,
	dlf_power_if.sink   sample,
	dlf_level_if.source result
);

	dlf_pkg::cmd_t  cmd;
	dlf_pkg::stat_t stat;
	logic           in_ready;
	logic           out_valid;
	logic [dlf_pkg::LEVEL_W-1:0] level_db;

	dlf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dlf_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.power_value (sample.power_value),
		.level_db    (level_db)
	);

	assign sample.ready    = in_ready;
	assign result.valid    = out_valid;
	assign result.level_db = level_db;

endmodule
